@@ rtl/psl_pkg.sv @@
// Shared constants, codes and handshake structs of the paced serial loopback.
package psl_pkg;

  localparam int FIFO_DEPTH = 32;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam int MAX_OUT    = 32;
  localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);
  localparam int SUM_W      = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

  localparam int RES_W      = 17;
  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TX_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RES_INC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RES_DIV = 3'd4;

  localparam logic [15:0] RES_INC_RST = 16'd9600;
  localparam logic [15:0] RES_DIV_RST = 16'd10000;

  // Function codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_INJECT = 2'd2;
  localparam logic [1:0] FUNC_BREAK  = 2'd3;

  // Pending error bits
  localparam int ERR_FRAME   = 0;
  localparam int ERR_PARITY  = 1;
  localparam int ERR_OVERRUN = 2;
  localparam int ERR_BREAK   = 3;

  // Received-byte flag codes
  localparam logic [1:0] FLAG_NONE   = 2'd0;
  localparam logic [1:0] FLAG_BREAK  = 2'd1;
  localparam logic [1:0] FLAG_FRAME  = 2'd2;
  localparam logic [1:0] FLAG_PARITY = 2'd3;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_REFUSED = 1'b1;

  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic calc;     // settle residual, byte count and flags of a tick
    logic pop;      // read one byte from the FIFO
  } psl_cmd_t;

  typedef struct packed {
    logic tick_go;    // incoming word is a tick with transmit enabled
    logic send_none;  // tick sends no byte
    logic send_last;  // current pop is the last of the burst
  } psl_sts_t;

endpackage

@@ rtl/paced_serial_loopback.sv @@
// Top level of the paced serial loopback: controller plus datapath.
//
// Usage:
//   Command channel: drive in_func and its fields with start; a word is
//   taken at a rising edge with start high and busy low. Write, inject and
//   break words finish at that edge. A tick with transmit enabled holds busy
//   through the calc state, which settles the residual accumulator, byte
//   count and error flags, then, if the burst is not empty, the send state,
//   which reads one FIFO byte per cycle via the single FIFO RAM read port.
//   Results: out_valid strobes one cycle per result, in the cycle after the
//   byte is read (or after a refused write is accepted); out_last marks the
//   final result of a word. Results of one tick come on consecutive cycles.
//   The receiver cannot stall; it must take every strobe.
//   With receive disabled the burst still drains the FIFO but strobes nothing.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//   register; cfg_ready is high whenever the block is not busy.
//   Reset (rst_n low, synchronous) empties the FIFO, clears the residual and
//   pending flags and loads the register defaults. No clearing pass is needed.
module paced_serial_loopback (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [7:0]                     in_data_byte,
  input  logic [2:0]                     in_error_mask,
  input  logic                           in_break_on,
  output logic                           out_valid,
  output logic                           out_kind,
  output logic [7:0]                     out_rx_byte,
  output logic [1:0]                     out_rx_flag,
  output logic                           out_overrun,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psl_pkg::*;

  psl_cmd_t cmd;
  psl_sts_t sts;
  logic     cfg_we;

  // Take register writes only between words
  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;

  psl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  psl_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_func),
    .in_data_byte  (in_data_byte),
    .in_error_mask (in_error_mask),
    .in_break_on   (in_break_on),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_rx_byte   (out_rx_byte),
    .out_rx_flag   (out_rx_flag),
    .out_overrun   (out_overrun),
    .out_last      (out_last)
  );

endmodule

@@ rtl/psl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/psl_ctrl.sv @@
// Controller state machine of the paced serial loopback.
module psl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  psl_pkg::psl_sts_t sts,
  output psl_pkg::psl_cmd_t cmd,
  output logic              busy
);
  import psl_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (sts.tick_go) begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        state_nxt = sts.send_none ? ST_IDLE : ST_SEND;
      end
      ST_SEND: begin
        cmd.pop = 1'b1;
        if (sts.send_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ rtl/psl_dp.sv @@
// Datapath: FIFO, rate accumulator, error flags, registers and result outputs.
module psl_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  psl_pkg::psl_cmd_t                cmd,
  output psl_pkg::psl_sts_t                sts,
  input  logic [1:0]                       in_func,
  input  logic [7:0]                       in_data_byte,
  input  logic [2:0]                       in_error_mask,
  input  logic                             in_break_on,
  input  logic                             cfg_we,
  input  logic [psl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  output logic                             out_kind,
  output logic [7:0]                       out_rx_byte,
  output logic [1:0]                       out_rx_flag,
  output logic                             out_overrun,
  output logic                             out_last
);
  import psl_pkg::*;

  // Configuration
  logic        tx_en_r;
  logic        rx_en_r;
  logic [5:0]  bpt_r;
  logic [15:0] res_inc_r;
  logic [15:0] res_div_r;

  // State
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [RES_W-1:0]     res_r, res_nxt;
  logic [3:0]           pend_r, pend_nxt;
  logic                 brk_rep_r, brk_rep_nxt;
  logic [OUT_CNT_W-1:0] remain_r, remain_nxt;
  logic                 first_r, first_nxt;
  logic [1:0]           flag_r, flag_nxt;
  logic                 ovr_r, ovr_nxt;

  // Result registers
  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [1:0] out_flag_r, out_flag_nxt;
  logic       out_ovr_r, out_ovr_nxt;
  logic       out_last_r, out_last_nxt;

  logic             ram_we;
  logic [7:0]       ram_rdata;
  logic             fifo_full;
  logic [RES_W:0]   res_sum;
  logic             res_ge;
  logic [SUM_W-1:0] quota_w, count_w, n1_w, n_w;
  logic             extra;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  psl_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (in_data_byte),
    .raddr (tail_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_en_r   <= 1'b0;
      rx_en_r   <= 1'b1;
      bpt_r     <= '0;
      res_inc_r <= RES_INC_RST;
      res_div_r <= RES_DIV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TX_EN:   tx_en_r   <= cfg_data[0];
        REG_RX_EN:   rx_en_r   <= cfg_data[0];
        REG_BPT:     bpt_r     <= cfg_data[5:0];
        REG_RES_INC: res_inc_r <= cfg_data;
        REG_RES_DIV: res_div_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign fifo_full = (count_r >= CNT_W'(FIFO_DEPTH));
  assign res_sum   = {1'b0, res_r} + (RES_W + 1)'(res_inc_r);
  assign res_ge    = (res_r >= RES_W'(res_div_r));

  // Burst size of a tick: clipped quota, then one residual byte if any is left
  assign quota_w = (SUM_W'(bpt_r) > SUM_W'(MAX_OUT - 1)) ? SUM_W'(MAX_OUT - 1)
                                                         : SUM_W'(bpt_r);
  assign count_w = SUM_W'(count_r);
  assign n1_w    = (count_w < quota_w) ? count_w : quota_w;
  assign extra   = res_ge && (count_w > n1_w);
  assign n_w     = n1_w + SUM_W'(extra);

  assign sts.tick_go   = (in_func == FUNC_TICK) && tx_en_r;
  assign sts.send_none = (n_w == '0);
  assign sts.send_last = (remain_r == OUT_CNT_W'(1));

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    pend_nxt      = pend_r;
    brk_rep_nxt   = brk_rep_r;
    remain_nxt    = remain_r;
    first_nxt     = first_r;
    flag_nxt      = flag_r;
    ovr_nxt       = ovr_r;
    ram_we        = 1'b0;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = KIND_BYTE;
    out_flag_nxt  = FLAG_NONE;
    out_ovr_nxt   = 1'b0;
    out_last_nxt  = 1'b0;

    if (cmd.accept) begin
      case (in_func)
        FUNC_WRITE: begin
          if (fifo_full) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_REFUSED;
            out_last_nxt  = 1'b1;
          end else begin
            ram_we    = 1'b1;
            head_nxt  = ptr_inc(head_r);
            count_nxt = count_r + 1'b1;
          end
        end
        FUNC_TICK: begin
          if (tx_en_r) begin
            res_nxt = res_sum[RES_W] ? RES_MAX : res_sum[RES_W-1:0];
          end
        end
        FUNC_INJECT: begin
          pend_nxt = pend_r | {1'b0, in_error_mask};
        end
        FUNC_BREAK: begin
          if (in_break_on) begin
            pend_nxt[ERR_BREAK] = 1'b1;
          end else if (pend_r[ERR_BREAK]) begin
            pend_nxt[ERR_BREAK] = 1'b0;
            brk_rep_nxt         = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.calc) begin
      if (res_ge) begin
        res_nxt = res_r - RES_W'(res_div_r);
      end
      remain_nxt = n_w[OUT_CNT_W-1:0];
      first_nxt  = 1'b1;
      // Consume pending flags: overrun always; break once, then frame, then parity
      ovr_nxt               = pend_r[ERR_OVERRUN];
      pend_nxt[ERR_OVERRUN] = 1'b0;
      if (pend_r[ERR_BREAK] && !brk_rep_r) begin
        brk_rep_nxt = 1'b1;
        flag_nxt    = FLAG_BREAK;
      end else if (pend_r[ERR_FRAME]) begin
        pend_nxt[ERR_FRAME] = 1'b0;
        flag_nxt            = FLAG_FRAME;
      end else if (pend_r[ERR_PARITY]) begin
        pend_nxt[ERR_PARITY] = 1'b0;
        flag_nxt             = FLAG_PARITY;
      end else begin
        flag_nxt = FLAG_NONE;
      end
    end

    if (cmd.pop) begin
      tail_nxt      = ptr_inc(tail_r);
      count_nxt     = count_r - 1'b1;
      remain_nxt    = remain_r - 1'b1;
      first_nxt     = 1'b0;
      out_valid_nxt = rx_en_r;
      out_kind_nxt  = KIND_BYTE;
      out_flag_nxt  = first_r ? flag_r : FLAG_NONE;
      out_ovr_nxt   = first_r ? ovr_r : 1'b0;
      out_last_nxt  = sts.send_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      res_r       <= '0;
      pend_r      <= '0;
      brk_rep_r   <= 1'b0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      res_r       <= res_nxt;
      pend_r      <= pend_nxt;
      brk_rep_r   <= brk_rep_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r    <= first_nxt;
    flag_r     <= flag_nxt;
    ovr_r      <= ovr_nxt;
    out_kind_r <= out_kind_nxt;
    out_flag_r <= out_flag_nxt;
    out_ovr_r  <= out_ovr_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_rx_byte = (out_kind_r == KIND_REFUSED) ? 8'h00 : ram_rdata;
  assign out_rx_flag = out_flag_r;
  assign out_overrun = out_ovr_r;
  assign out_last    = out_last_r;

endmodule

@@ rtl/psl_checker.sv @@
// Port-level checker of the paced serial loopback, bound to the top level.
module psl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [1:0]                     in_func,
  input logic                           out_valid,
  input logic                           out_kind,
  input logic [7:0]                     out_rx_byte,
  input logic [1:0]                     out_rx_flag,
  input logic                           out_overrun,
  input logic                           out_last
);
  import psl_pkg::*;

  // A refused write is a single, empty result
  a_refused_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last && out_rx_byte == 8'h00 &&
                              out_rx_flag == FLAG_NONE && !out_overrun)
    else $error("refused write result malformed");

  // A refusal answers a write word taken in the previous cycle
  a_refused_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> $past(start && !busy && in_func == FUNC_WRITE))
    else $error("refusal without a write word");

  // Bytes of a burst come on consecutive cycles
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && !out_kind)
    else $error("gap inside a burst");

  // Only the first byte of a burst carries flag and overrun
  a_flag_first_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_rx_flag == FLAG_NONE && !out_overrun)
    else $error("flag on a later byte of a burst");

endmodule

bind paced_serial_loopback psl_checker u_psl_checker (.*);

@@ bench/paced_serial_loopback_tb.sv @@
// Testbench of the paced serial loopback: directed and random words checked against a predictor.
`timescale 1ns / 100ps

module paced_serial_loopback_tb;
  import psl_pkg::*;

  localparam int SETTLE_CYCLES = MAX_OUT + 8;  // longest tick, plus margin
  localparam int QUIET_LIMIT   = 1000;         // cycles with no handshake before giving up

  // One received byte or refusal as the block reports it.
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic [1:0] rx_flag;
    logic       overrun;
    logic       last;
  } rx_word_t;

  // Tracks FIFO, rate accumulator and error flags, and holds the received
  // words that the accepted command words must still produce, oldest first.
  class paced_rx_tracker;
    logic [7:0]       fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    int unsigned      fill;
    logic [RES_W-1:0] residual;
    logic [3:0]       pending;
    bit               brk_shown;
    bit               tx_en;
    bit               rx_en;
    logic [5:0]       bpt;
    logic [15:0]      res_inc;
    logic [15:0]      res_div;
    rx_word_t         rx_due [$];
    int               errors;

    function new();
      head      = '0;
      tail      = '0;
      fill      = 0;
      residual  = '0;
      pending   = '0;
      brk_shown = 0;
      tx_en     = 0;
      rx_en     = 1;
      bpt       = '0;
      res_inc   = RES_INC_RST;
      res_div   = RES_DIV_RST;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TX_EN:   tx_en   = val[0];
        REG_RX_EN:   rx_en   = val[0];
        REG_BPT:     bpt     = val[5:0];
        REG_RES_INC: res_inc = val;
        REG_RES_DIV: res_div = val;
        default: ;
      endcase
    endfunction

    function logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function logic [7:0] pop_byte();
      logic [7:0] b;
      b    = fifo_mem[tail];
      tail = ptr_next(tail);
      fill--;
      return b;
    endfunction

    // With transmit enabled, drain one tick's burst and consume the pending flags.
    function void pace_tick();
      int         quota;
      logic [RES_W:0] acc;
      logic [7:0] burst [$];
      logic [1:0] flag;
      logic       ovr;
      rx_word_t   w;
      if (!tx_en) return;
      quota = (int'(bpt) > MAX_OUT - 1) ? MAX_OUT - 1 : int'(bpt);
      acc = {1'b0, residual} + (RES_W + 1)'(res_inc);
      if (acc > {1'b0, RES_MAX}) acc = {1'b0, RES_MAX};
      residual = acc[RES_W-1:0];
      while (fill > 0 && quota > 0) begin
        burst.push_back(pop_byte());
        quota--;
      end
      // zero divisor: always reached, nothing subtracted
      if (residual >= RES_W'(res_div)) begin
        residual = residual - RES_W'(res_div);
        if (fill > 0 && burst.size() < MAX_OUT) burst.push_back(pop_byte());
      end
      ovr  = pending[ERR_OVERRUN];
      flag = FLAG_NONE;
      pending[ERR_OVERRUN] = 1'b0;
      if (pending[ERR_BREAK] && !brk_shown) begin
        brk_shown = 1;          // break stays pending, reported only once
        flag = FLAG_BREAK;
      end else if (pending[ERR_FRAME]) begin
        pending[ERR_FRAME] = 1'b0;
        flag = FLAG_FRAME;
      end else if (pending[ERR_PARITY]) begin
        pending[ERR_PARITY] = 1'b0;
        flag = FLAG_PARITY;
      end
      if (!rx_en) return;       // flags are lost along with the bytes
      foreach (burst[k]) begin
        w = '{kind: KIND_BYTE, rx_byte: burst[k],
              rx_flag: (k == 0) ? flag : FLAG_NONE,
              overrun: (k == 0) ? ovr : 1'b0,
              last: (k == burst.size() - 1)};
        rx_due.push_back(w);
      end
    endfunction

    function void take_word(logic [1:0] func, logic [7:0] data, logic [2:0] mask, logic brk);
      case (func)
        FUNC_WRITE: begin
          if (fill >= FIFO_DEPTH) begin
            rx_due.push_back('{kind: KIND_REFUSED, rx_byte: 8'h00, rx_flag: FLAG_NONE,
                               overrun: 1'b0, last: 1'b1});
          end else begin
            fifo_mem[head] = data;
            head = ptr_next(head);
            fill++;
          end
        end
        FUNC_INJECT: pending[2:0] = pending[2:0] | mask;
        FUNC_BREAK: begin
          if (brk) begin
            pending[ERR_BREAK] = 1'b1;
          end else if (pending[ERR_BREAK]) begin
            pending[ERR_BREAK] = 1'b0;
            brk_shown = 0;
          end
        end
        default: pace_tick();
      endcase
    endfunction

    function void check_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void match_rx(rx_word_t got);
      rx_word_t exp_w;
      if (rx_due.size() == 0) begin
        $error("unexpected received word: kind %0d byte %0d flag %0d", got.kind,
               got.rx_byte, got.rx_flag);
        errors++;
        return;
      end
      exp_w = rx_due.pop_front();
      check_field("kind", int'(exp_w.kind), int'(got.kind));
      check_field("rx_byte", int'(exp_w.rx_byte), int'(got.rx_byte));
      check_field("rx_flag", int'(exp_w.rx_flag), int'(got.rx_flag));
      check_field("overrun", int'(exp_w.overrun), int'(got.overrun));
      check_field("last", int'(exp_w.last), int'(got.last));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_func = FUNC_WRITE;
  logic [7:0]            in_data_byte = '0;
  logic [2:0]            in_error_mask = '0;
  logic                  in_break_on = 1'b0;
  logic                  out_valid;
  logic                  out_kind;
  logic [7:0]            out_rx_byte;
  logic [1:0]            out_rx_flag;
  logic                  out_overrun;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TX_EN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  paced_rx_tracker tracker = new();
  int quiet_cycles = 0;
  bit gaps_on = 1;

  paced_serial_loopback dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .in_error_mask(in_error_mask),
    .in_break_on  (in_break_on),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_rx_byte  (out_rx_byte),
    .out_rx_flag  (out_rx_flag),
    .out_overrun  (out_overrun),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Sample every handshake at the rising edge. Check results before noting the
  // incoming word: a word taken at this edge cannot have a result out yet.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        tracker.match_rx('{kind: out_kind, rx_byte: out_rx_byte, rx_flag: out_rx_flag,
                           overrun: out_overrun, last: out_last});
      end
      if (start && !busy) tracker.take_word(in_func, in_data_byte, in_error_mask, in_break_on);
      if (cfg_valid && cfg_ready) tracker.set_reg(cfg_index, cfg_data);
      // reset the stall count on any handshake
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one command word from a falling edge; hold start until busy drops.
  task automatic send_word(logic [1:0] func, logic [7:0] data, logic [2:0] mask,
                           logic brk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start         = 1'b1;
    in_func       = func;
    in_data_byte  = data;
    in_error_mask = mask;
    in_break_on   = brk;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait out every expected word, then the longest tick that owes nothing.
  task automatic settle();
    start = 1'b0;
    while (tracker.rx_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Quiesce, then load all five registers.
  task automatic load_rates(bit tx, bit rx, logic [5:0] bpt, logic [15:0] inc,
                            logic [15:0] div);
    settle();
    write_reg(REG_TX_EN, {15'd0, tx});
    write_reg(REG_RX_EN, {15'd0, rx});
    write_reg(REG_BPT, {10'd0, bpt});
    write_reg(REG_RES_INC, inc);
    write_reg(REG_RES_DIV, div);
  endtask

  // Mix of writes (write_pct percent) with ticks, error injection and break control.
  task automatic random_words(int count, int write_pct);
    int r;
    logic [1:0] func;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < write_pct) func = FUNC_WRITE;
      else if ($urandom_range(0, 9) < 6) func = FUNC_TICK;
      else if ($urandom_range(0, 1) == 0) func = FUNC_INJECT;
      else func = FUNC_BREAK;
      send_word(func, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)));
    end
  endtask

  // Abort the run if handshakes stop.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme bytes, all error kinds with break priority, break off
    // twice, tick on an empty FIFO, frame after break is cleared.
    load_rates(1, 1, 6'd1, 16'd9600, 16'd10000);
    send_word(FUNC_WRITE, 8'h00, 3'd0, 1'b0);
    send_word(FUNC_WRITE, 8'hFF, 3'd7, 1'b1);
    send_word(FUNC_WRITE, 8'h5A, 3'd0, 1'b0);
    send_word(FUNC_WRITE, 8'hA5, 3'd0, 1'b0);
    send_word(FUNC_INJECT, 8'h00, 3'd7, 1'b0);
    send_word(FUNC_BREAK, 8'h00, 3'd0, 1'b1);
    repeat (4) send_word(FUNC_TICK, 8'hFF, 3'd7, 1'b1);
    send_word(FUNC_BREAK, 8'hFF, 3'd7, 1'b0);
    send_word(FUNC_BREAK, 8'hFF, 3'd7, 1'b0);
    send_word(FUNC_INJECT, 8'hFF, 3'd1, 1'b1);
    send_word(FUNC_WRITE, 8'h3C, 3'd0, 1'b0);
    send_word(FUNC_TICK, 8'h00, 3'd0, 1'b0);

    // Transmit off: ticks do nothing, mostly writes to fill and overflow the FIFO.
    load_rates(0, 1, 6'd5, 16'd0, 16'd1);
    random_words(45, 95);

    // Widest burst from the full FIFO: quota clipped, extra byte, residual saturates.
    load_rates(1, 1, 6'd32, 16'hFFFF, 16'd1);
    send_word(FUNC_TICK, 8'h00, 3'd0, 1'b0);
    random_words(30, 50);

    // Receive off: bursts drain silently and flags are lost.
    load_rates(1, 0, 6'd3, 16'd0, 16'hFFFF);
    random_words(30, 60);

    // Zero divisor: one extra byte per tick if the FIFO holds one, accumulator pinned at its maximum.
    load_rates(1, 1, 6'd0, 16'hFFFF, 16'd0);
    random_words(30, 55);

    repeat (3) begin
      load_rates(1, $urandom_range(0, 3) != 0, 6'($urandom_range(0, 32)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)));
      random_words(35, 55);
    end

    // Last stretch back to back with no gaps.
    gaps_on = 0;
    load_rates(1, 1, 6'($urandom_range(0, 32)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(1, 65535)));
    random_words(40, 55);

    settle();
    if (tracker.errors == 0 && tracker.rx_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
